### rtl/clx_pkg.sv
// Shared constants, codes and character helpers for the configuration text lexer.
package clx_pkg;

  // Default widths of the position counters and depth of the queue between front and back.
  localparam int LINE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int KIND_W = 3;
  localparam int MODE_W = 3;

  // Lexer modes.
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMENT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DIGITRUN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PATH     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IDENT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd5;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_COMMENT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SIZE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STRING  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PATH    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd7;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_UP_M   = 8'h4D;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_SEMI);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return is_space(c) || (c == CH_HASH) || is_sym(c);
  endfunction

  function automatic logic is_unit(input logic [7:0] c);
    return (c == CH_UP_K) || (c == CH_UP_M) || (c == CH_UP_G);
  endfunction

endpackage

### rtl/clx_in_if.sv
// Byte channel into the lexer: valid/ready handshake with one text byte per item.
interface clx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source(output valid, text_byte, end_of_input, input ready);
  modport sink(input valid, text_byte, end_of_input, output ready);
endinterface

### rtl/clx_out_if.sv
// Token channel out of the lexer: valid/ready handshake with one token record per item.
interface clx_out_if #(
  parameter int LINE_BITS   = clx_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = clx_pkg::OFFSET_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [clx_pkg::KIND_W-1:0] token_kind;
  logic [LINE_BITS-1:0]      token_line;
  logic [LINE_BITS-1:0]      token_column;
  logic [OFFSET_BITS-1:0]    token_offset;
  logic [OFFSET_BITS-1:0]    token_length;
  logic                      last_of_byte;

  modport source(output valid, token_kind, token_line, token_column, token_offset,
                 token_length, last_of_byte, input ready);
  modport sink(input valid, token_kind, token_line, token_column, token_offset,
               token_length, last_of_byte, output ready);
endinterface

### rtl/clx_front.sv
// Lexer front: one byte per cycle unless full; tracks position; records up to two tokens.
module clx_front #(
  parameter int LINE_BITS   = clx_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = clx_pkg::OFFSET_BITS_DEF,
  parameter int REC_W       = 1 + 2 * (clx_pkg::KIND_W + 1 + 2 * LINE_BITS + 2 * OFFSET_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  clx_in_if.sink           in,
  output logic             push,
  output logic [REC_W-1:0] push_data,
  input  logic             full
);

  typedef struct packed {
    logic [clx_pkg::KIND_W-1:0] kind;
    logic [LINE_BITS-1:0]       line;
    logic [LINE_BITS-1:0]       column;
    logic [OFFSET_BITS-1:0]     offset;
    logic [OFFSET_BITS-1:0]     length;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } record_t;

  logic [clx_pkg::MODE_W-1:0] mode, mode_next;
  logic [LINE_BITS-1:0]       line_count, line_count_next;
  logic [LINE_BITS-1:0]       column_count, column_count_next;
  logic [OFFSET_BITS-1:0]     byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]       start_line, start_line_next;
  logic [LINE_BITS-1:0]       start_column, start_column_next;
  logic [OFFSET_BITS-1:0]     start_offset, start_offset_next;
  logic [OFFSET_BITS-1:0]     run_length, run_length_next;
  logic                       all_digits, all_digits_next;
  logic                       prefix_digits, prefix_digits_next;
  logic                       suffix_letter, suffix_letter_next;

  logic       accept;
  logic [7:0] c;
  logic [1:0] cnt;
  logic       do_idle;
  result_t    slot [2];

  // Close the open token: its kind follows from mode and the digit flags.
  function automatic result_t open_res(
    input logic [clx_pkg::MODE_W-1:0] m,
    input logic                       ad,
    input logic                       pd,
    input logic                       sl,
    input logic [LINE_BITS-1:0]       ln,
    input logic [LINE_BITS-1:0]       col,
    input logic [OFFSET_BITS-1:0]     off,
    input logic [OFFSET_BITS-1:0]     len
  );
    result_t r;
    r.line   = ln;
    r.column = col;
    r.offset = off;
    r.length = len;
    r.last   = 1'b0;
    if (m == clx_pkg::MODE_COMMENT) begin
      r.kind = clx_pkg::KIND_COMMENT;
    end else if (m == clx_pkg::MODE_PATH) begin
      r.kind = clx_pkg::KIND_PATH;
    end else if (m == clx_pkg::MODE_IDENT) begin
      r.kind = clx_pkg::KIND_IDENT;
    end else if (ad) begin
      r.kind = clx_pkg::KIND_NUMBER;
    end else if (pd && sl) begin
      r.kind = clx_pkg::KIND_SIZE;
    end else begin
      r.kind = clx_pkg::KIND_STRING;
    end
    return r;
  endfunction

  function automatic result_t here_res(
    input logic [clx_pkg::KIND_W-1:0] k,
    input logic [LINE_BITS-1:0]       ln,
    input logic [LINE_BITS-1:0]       col,
    input logic [OFFSET_BITS-1:0]     off,
    input logic [OFFSET_BITS-1:0]     len
  );
    result_t r;
    r.kind   = k;
    r.line   = ln;
    r.column = col;
    r.offset = off;
    r.length = len;
    r.last   = 1'b0;
    return r;
  endfunction

  assign in.ready = !full;
  assign accept   = in.valid && in.ready;
  assign c        = in.text_byte;

  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    column_count_next  = column_count;
    byte_offset_next   = byte_offset;
    start_line_next    = start_line;
    start_column_next  = start_column;
    start_offset_next  = start_offset;
    run_length_next    = run_length;
    all_digits_next    = all_digits;
    prefix_digits_next = prefix_digits;
    suffix_letter_next = suffix_letter;
    cnt                = 2'd0;
    do_idle            = 1'b0;
    slot[0]            = '0;
    slot[1]            = '0;

    case (mode)
      clx_pkg::MODE_ERROR: begin
        // drop bytes until end of input
      end
      clx_pkg::MODE_COMMENT: begin
        if (run_length != '1) run_length_next = run_length + 1'b1;
        if (c == clx_pkg::CH_LF) begin
          slot[cnt[0]] = open_res(mode, all_digits, prefix_digits, suffix_letter,
                                  start_line, start_column, start_offset, run_length_next);
          cnt       = cnt + 2'd1;
          mode_next = clx_pkg::MODE_IDLE;
        end
      end
      clx_pkg::MODE_DIGITRUN, clx_pkg::MODE_PATH, clx_pkg::MODE_IDENT: begin
        if (clx_pkg::is_term(c)) begin
          slot[cnt[0]] = open_res(mode, all_digits, prefix_digits, suffix_letter,
                                  start_line, start_column, start_offset, run_length);
          cnt     = cnt + 2'd1;
          do_idle = 1'b1;
        end else if ((mode == clx_pkg::MODE_IDENT) && !clx_pkg::is_alpha(c) &&
                     (c != clx_pkg::CH_DASH)) begin
          slot[cnt[0]] = here_res(clx_pkg::KIND_ERROR, line_count, column_count,
                                  byte_offset, '0);
          cnt       = cnt + 2'd1;
          mode_next = clx_pkg::MODE_ERROR;
        end else begin
          if (run_length != '1) run_length_next = run_length + 1'b1;
          prefix_digits_next = all_digits;
          all_digits_next    = all_digits && clx_pkg::is_dig(c);
          suffix_letter_next = clx_pkg::is_unit(c);
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Between tokens: skip whitespace, start a new one, or report a symbol or a bad byte.
    if (do_idle) begin
      mode_next = clx_pkg::MODE_IDLE;
      if (clx_pkg::is_space(c)) begin
        mode_next = clx_pkg::MODE_IDLE;
      end else if (clx_pkg::is_sym(c)) begin
        slot[cnt[0]] = here_res(clx_pkg::KIND_SYMBOL, line_count, column_count,
                                byte_offset, OFFSET_BITS'(1));
        cnt = cnt + 2'd1;
      end else if ((c == clx_pkg::CH_HASH) || clx_pkg::is_dig(c) ||
                   (c == clx_pkg::CH_SLASH) || (c == clx_pkg::CH_DOT) ||
                   clx_pkg::is_alpha(c)) begin
        if (c == clx_pkg::CH_HASH) begin
          mode_next = clx_pkg::MODE_COMMENT;
        end else if (clx_pkg::is_dig(c)) begin
          mode_next = clx_pkg::MODE_DIGITRUN;
        end else if (clx_pkg::is_alpha(c)) begin
          mode_next = clx_pkg::MODE_IDENT;
        end else begin
          mode_next = clx_pkg::MODE_PATH;
        end
        start_line_next    = line_count;
        start_column_next  = column_count;
        start_offset_next  = byte_offset;
        run_length_next    = OFFSET_BITS'(1);
        all_digits_next    = 1'b1;
        prefix_digits_next = 1'b1;
        suffix_letter_next = 1'b0;
      end else begin
        slot[cnt[0]] = here_res(clx_pkg::KIND_ERROR, line_count, column_count,
                                byte_offset, '0);
        cnt       = cnt + 2'd1;
        mode_next = clx_pkg::MODE_ERROR;
      end
    end

    // Advance the position counters; line and column saturate, offset wraps.
    byte_offset_next = byte_offset + 1'b1;
    if (c == clx_pkg::CH_LF) begin
      if (line_count != '1) line_count_next = line_count + 1'b1;
      column_count_next = LINE_BITS'(1);
    end else if (column_count != '1) begin
      column_count_next = column_count + 1'b1;
    end

    // End of input: flush the open token, then return to the reset state.
    if (in.end_of_input) begin
      if ((mode_next == clx_pkg::MODE_COMMENT) || (mode_next == clx_pkg::MODE_DIGITRUN) ||
          (mode_next == clx_pkg::MODE_PATH) || (mode_next == clx_pkg::MODE_IDENT)) begin
        slot[cnt[0]] = open_res(mode_next, all_digits_next, prefix_digits_next,
                                suffix_letter_next, start_line_next, start_column_next,
                                start_offset_next, run_length_next);
        cnt = cnt + 2'd1;
      end
      mode_next          = clx_pkg::MODE_IDLE;
      line_count_next    = LINE_BITS'(1);
      column_count_next  = LINE_BITS'(1);
      byte_offset_next   = '0;
      start_line_next    = LINE_BITS'(1);
      start_column_next  = LINE_BITS'(1);
      start_offset_next  = '0;
      run_length_next    = '0;
      all_digits_next    = 1'b1;
      prefix_digits_next = 1'b1;
      suffix_letter_next = 1'b0;
    end

    if (cnt == 2'd1) slot[0].last = 1'b1;
    if (cnt == 2'd2) slot[1].last = 1'b1;
  end

  assign push      = accept && (cnt != 2'd0);
  assign push_data = REC_W'({(cnt == 2'd2), slot[0], slot[1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= clx_pkg::MODE_IDLE;
      line_count    <= LINE_BITS'(1);
      column_count  <= LINE_BITS'(1);
      byte_offset   <= '0;
      start_line    <= LINE_BITS'(1);
      start_column  <= LINE_BITS'(1);
      start_offset  <= '0;
      run_length    <= '0;
      all_digits    <= 1'b1;
      prefix_digits <= 1'b1;
      suffix_letter <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      byte_offset   <= byte_offset_next;
      start_line    <= start_line_next;
      start_column  <= start_column_next;
      start_offset  <= start_offset_next;
      run_length    <= run_length_next;
      all_digits    <= all_digits_next;
      prefix_digits <= prefix_digits_next;
      suffix_letter <= suffix_letter_next;
    end
  end

`ifndef SYNTHESIS
  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in.end_of_input |=>
      (line_count == LINE_BITS'(1)) && (byte_offset == '0) && (mode == clx_pkg::MODE_IDLE))
    else $error("position not reset after end of input");
`endif

endmodule

### rtl/clx_queue.sv
// Short queue of token records between the lexer front and the output back.
module clx_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = clx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");
`endif

endmodule

### rtl/clx_back.sv
// Lexer back: pops token records and hands them out one token per item.
module clx_back #(
  parameter int LINE_BITS   = clx_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = clx_pkg::OFFSET_BITS_DEF,
  parameter int REC_W       = 1 + 2 * (clx_pkg::KIND_W + 1 + 2 * LINE_BITS + 2 * OFFSET_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [REC_W-1:0] head,
  input  logic             head_valid,
  output logic             pop,
  clx_out_if.source        out
);

  typedef struct packed {
    logic [clx_pkg::KIND_W-1:0] kind;
    logic [LINE_BITS-1:0]       line;
    logic [LINE_BITS-1:0]       column;
    logic [OFFSET_BITS-1:0]     offset;
    logic [OFFSET_BITS-1:0]     length;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } record_t;

  record_t rec;
  logic    out_valid, pend_valid, load;
  result_t out_data, pend_data;

  assign rec  = record_t'(head);
  assign load = !out_valid || out.ready;
  // A held second token goes out before the next record is taken.
  assign pop  = load && !pend_valid && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= head_valid;
        pend_valid <= head_valid && rec.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_data <= pend_data;
      end else if (head_valid) begin
        out_data  <= rec.first;
        pend_data <= rec.second;
      end
    end
  end

  assign out.valid        = out_valid;
  assign out.token_kind   = out_data.kind;
  assign out.token_line   = out_data.line;
  assign out.token_column = out_data.column;
  assign out.token_offset = out_data.offset;
  assign out.token_length = out_data.length;
  assign out.last_of_byte = out_data.last;

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second token held with no first token shown");
`endif

endmodule

### rtl/config_text_lexer.sv
// Top level of the configuration text lexer: front, record queue and output back.
//
// Use: feed configuration text on "in", one byte per item (text_byte), and set
// end_of_input on the final byte. Tokens come out on "out", one per item: kind,
// line, column, byte offset of the token start, and length. Whitespace makes no
// token; a byte can give zero, one or two tokens, and last_of_byte marks the last
// one a byte gives. After a bad byte an error token is given and bytes are dropped
// without tokens until end_of_input. end_of_input flushes any open token and then
// returns line, column and offset to their start values.
// Throughput: one byte per cycle while the queue is not full; the front closes
// each byte in the cycle it is taken. A byte that gives two tokens holds the
// output register for both, so bytes that keep giving two tokens fill the queue
// and slow "in". Path: the edge that takes a byte writes its record to the
// queue; from there its first token is loaded into the output register, which
// drives "out", once the record is at the head and the register is free.
// Stall: while "out" is stalled the output register holds its token and the
// queue of QUEUE_DEPTH records fills; "in" drops ready only when the queue is full.
// Reset (rst, synchronous): clears the queue, the output register and all
// position counters; no clearing pass is needed.
module config_text_lexer #(
  parameter int LINE_BITS   = clx_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = clx_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = clx_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  clx_in_if.sink    in,
  clx_out_if.source out
);

  // One record: a two-token flag and two token slots.
  localparam int REC_W = 1 + 2 * (clx_pkg::KIND_W + 1 + 2 * LINE_BITS + 2 * OFFSET_BITS);

  logic             push, full, pop, not_empty;
  logic [REC_W-1:0] push_data, pop_data;

  // Classify bytes and track position; push a record for bytes that give tokens.
  clx_front #(
    .LINE_BITS  (LINE_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in       (in),
    .push     (push),
    .push_data(push_data),
    .full     (full)
  );

  // Decouple the byte side from the token side.
  clx_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .not_empty(not_empty)
  );

  // Split each record into tokens and drive the output register.
  clx_back #(
    .LINE_BITS  (LINE_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (pop_data),
    .head_valid(not_empty),
    .pop       (pop),
    .out       (out)
  );

endmodule
